### hdl/chd_pkg.sv
`default_nettype none
package chd_pkg;

  localparam int LENGTH_BITS = 20;
  localparam int NODE_W      = 9;
  localparam int WEIGHT_W    = 16;
  localparam int SYM_W       = 8;
  localparam int NUM_SYMS    = 256;
  localparam int NODE_COUNT  = 511;
  // child entries are addressed as {context, node - 256, branch}
  localparam int CHILD_DEPTH = 131072;

  localparam logic [NODE_W-1:0] FIRST_INNER = 9'd256;
  localparam logic [NODE_W-1:0] LAST_INNER  = 9'd510;
  localparam logic [NODE_W-1:0] NODE_BAD    = 9'd511;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_BYTE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_BIT,
    S_ROOT,
    S_CHILD,
    S_SCAN,
    S_PICK,
    S_MERGE,
    S_FINISH
  } state_t;

  function automatic logic is_inner(input logic [NODE_W-1:0] node);
    return node[NODE_W-1] && (node != NODE_BAD);
  endfunction

endpackage
`default_nettype wire

### hdl/chd_ram.sv
`default_nettype none
module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/context_huffman_decoder_core.sv
`default_nettype none
// Order-1 context Huffman decoder: one code tree per previous symbol, kept in a
// child memory, a root memory and a node weight memory. One item at a time is
// worked on. A count load writes one leaf weight. The load of symbol 255 builds
// that context's tree. Each of up to 255 merges scans the weight memory twice
// over all nodes made so far, one read a cycle; each scan drains before its
// pick. A start reads the root of context 0. A compressed byte does a child
// read per bit and a root read for every symbol decoded; it ends early on the
// final symbol. A new item is taken while a result waits at the output; the
// decoder only stalls when it has a further result to hand over.
module context_huffman_decoder_core
  import chd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             operation,
  input  wire logic [7:0]             context_req,
  input  wire logic [7:0]             symbol_index,
  input  wire logic [7:0]             data_byte,
  input  wire logic [LENGTH_BITS-1:0] frame_length,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  symbol,
  output logic                        last,
  output logic                        bad_tree
);

  state_t state, state_next;

  logic [LENGTH_BITS-1:0] symbols_left;
  logic [NODE_W-1:0]      current_node;
  logic [SYM_W-1:0]       current_context;
  logic [SYM_W-1:0]       byte_reg;
  logic [2:0]             bit_idx;
  logic [SYM_W-1:0]       pend_sym;

  logic [SYM_W-1:0]       build_ctx;
  logic [NODE_W-1:0]      made;
  logic                   which;
  logic [NODE_W-1:0]      issue_idx;
  logic                   rd_vld;
  logic [NODE_W-1:0]      rd_idx;
  logic                   found;
  logic [NODE_W-1:0]      best_idx;
  logic [WEIGHT_W-1:0]    best_w;
  logic [WEIGHT_W-1:0]    a_w;
  logic [NUM_SYMS-1:0]    leaf_valid;

  // memory ports
  logic                 w_we, w_re;
  logic [NODE_W-1:0]    w_waddr, w_raddr;
  logic [WEIGHT_W:0]    w_wdata, w_rdata;
  logic                 c_we, c_re;
  logic [16:0]          c_waddr, c_raddr;
  logic [NODE_W-1:0]    c_wdata, c_rdata;
  logic                 r_we, r_re;
  logic [SYM_W-1:0]     r_waddr, r_raddr;
  logic [NODE_W-1:0]    r_wdata, r_rdata;

  logic                 emit, emit_last, emit_bad;
  logic [SYM_W-1:0]     emit_sym;
  logic                 slot_free;
  logic                 start_bad;
  logic                 cur_bit;
  logic                 scan_end;
  logic [WEIGHT_W-1:0]  eff_w;
  logic                 cand;

  chd_ram #(.WIDTH(WEIGHT_W + 1), .DEPTH(NODE_COUNT)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
  );

  chd_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  chd_ram #(.WIDTH(NODE_W), .DEPTH(NUM_SYMS)) u_root (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
  );

  assign slot_free = !out_valid || out_ready;
  assign start_bad = (symbols_left != '0) && !is_inner(r_rdata);
  assign cur_bit   = byte_reg[bit_idx];
  assign scan_end  = (issue_idx == made) && !rd_vld;
  // a leaf not loaded since the last build weighs zero
  assign eff_w     = (!rd_idx[NODE_W-1] && !leaf_valid[rd_idx[SYM_W-1:0]]) ?
                     '0 : w_rdata[WEIGHT_W-1:0];
  assign cand      = !w_rdata[WEIGHT_W] && (eff_w != '0) && (!found || eff_w < best_w);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(operation))
            OP_LOAD:  if (symbol_index == 8'hFF) state_next = S_SCAN;
            OP_START: state_next = S_START;
            OP_BYTE:  if (symbols_left != '0) state_next = S_BIT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_START: begin
        if (!start_bad || slot_free) state_next = S_IDLE;
      end
      S_BIT: begin
        if (!current_node[NODE_W-1]) begin
          if (symbols_left != LENGTH_BITS'(1)) state_next = S_ROOT;
          else if (slot_free) state_next = S_IDLE;
        end else if (current_node == NODE_BAD) begin
          if (slot_free) state_next = S_IDLE;
        end else begin
          state_next = S_CHILD;
        end
      end
      S_ROOT: begin
        if (slot_free) state_next = is_inner(r_rdata) ? S_CHILD : S_IDLE;
      end
      S_CHILD: begin
        state_next = (bit_idx == 3'd7) ? S_IDLE : S_BIT;
      end
      S_SCAN: begin
        if (scan_end) state_next = S_PICK;
      end
      S_PICK: begin
        if (!found) state_next = S_FINISH;
        else if (!which) state_next = S_SCAN;
        else state_next = S_MERGE;
      end
      S_MERGE: begin
        state_next = (made == LAST_INNER) ? S_FINISH : S_SCAN;
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory controls and results
  always_comb begin
    in_ready  = 1'b0;
    w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_re = 1'b0; w_raddr = '0;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
    r_we = 1'b0; r_waddr = '0; r_wdata = '0; r_re = 1'b0; r_raddr = '0;
    emit = 1'b0; emit_sym = '0; emit_last = 1'b0; emit_bad = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && op_t'(operation) == OP_LOAD) begin
          w_we    = 1'b1;
          w_waddr = {1'b0, symbol_index};
          w_wdata = {1'b0, 8'd0, data_byte};
        end
        if (in_valid && op_t'(operation) == OP_START) begin
          r_re    = 1'b1;
          r_raddr = '0;
        end
      end
      S_START: begin
        if (start_bad && slot_free) begin
          emit = 1'b1; emit_last = 1'b1; emit_bad = 1'b1;
        end
      end
      S_BIT: begin
        if (!current_node[NODE_W-1]) begin
          if (symbols_left == LENGTH_BITS'(1)) begin
            emit      = slot_free;
            emit_sym  = current_node[SYM_W-1:0];
            emit_last = 1'b1;
          end else begin
            r_re    = 1'b1;
            r_raddr = current_node[SYM_W-1:0];
          end
        end else if (current_node == NODE_BAD) begin
          emit = slot_free; emit_last = 1'b1; emit_bad = 1'b1;
        end else begin
          c_re    = 1'b1;
          c_raddr = {current_context, current_node[SYM_W-1:0], cur_bit};
        end
      end
      S_ROOT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_sym  = pend_sym;
          emit_last = !is_inner(r_rdata);
          emit_bad  = !is_inner(r_rdata);
          if (is_inner(r_rdata)) begin
            c_re    = 1'b1;
            c_raddr = {current_context, r_rdata[SYM_W-1:0], cur_bit};
          end
        end
      end
      S_SCAN: begin
        if (issue_idx != made) begin
          w_re    = 1'b1;
          w_raddr = issue_idx;
        end
      end
      S_PICK: begin
        if (found) begin
          w_we    = 1'b1;
          w_waddr = best_idx;
          w_wdata = {1'b1, best_w};
          c_we    = 1'b1;
          c_waddr = {build_ctx, made[SYM_W-1:0], which};
          c_wdata = best_idx;
        end
      end
      S_MERGE: begin
        w_we    = 1'b1;
        w_waddr = made;
        w_wdata = {1'b0, 16'(a_w + best_w)};
      end
      S_FINISH: begin
        r_we    = 1'b1;
        r_waddr = build_ctx;
        r_wdata = 9'(made - 9'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      symbols_left    <= '0;
      current_node    <= '0;
      current_context <= '0;
      leaf_valid      <= '0;
      rd_vld          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (emit) begin
        out_valid <= 1'b1;
        symbol    <= emit_sym;
        last      <= emit_last;
        bad_tree  <= emit_bad;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (op_t'(operation))
              OP_LOAD: begin
                leaf_valid[symbol_index] <= 1'b1;
                if (symbol_index == 8'hFF) begin
                  build_ctx <= context_req;
                  made      <= FIRST_INNER;
                  which     <= 1'b0;
                  issue_idx <= '0;
                  found     <= 1'b0;
                  rd_vld    <= 1'b0;
                end
              end
              OP_START: begin
                symbols_left    <= frame_length;
                current_context <= '0;
              end
              OP_BYTE: begin
                byte_reg <= data_byte;
                bit_idx  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_START: begin
          current_node <= r_rdata;
          if (start_bad && slot_free) symbols_left <= '0;
        end
        S_BIT: begin
          if (!current_node[NODE_W-1]) begin
            if (symbols_left != LENGTH_BITS'(1)) begin
              symbols_left    <= symbols_left - LENGTH_BITS'(1);
              current_context <= current_node[SYM_W-1:0];
              pend_sym        <= current_node[SYM_W-1:0];
            end else if (slot_free) begin
              symbols_left <= '0;
            end
          end else if (current_node == NODE_BAD && slot_free) begin
            symbols_left <= '0;
          end
        end
        S_ROOT: begin
          if (slot_free) begin
            current_node <= r_rdata;
            if (!is_inner(r_rdata)) symbols_left <= '0;
          end
        end
        S_CHILD: begin
          current_node <= c_rdata;
          bit_idx      <= bit_idx + 3'd1;
        end
        S_SCAN: begin
          rd_vld <= (issue_idx != made);
          rd_idx <= issue_idx;
          if (issue_idx != made) issue_idx <= issue_idx + 9'd1;
          if (rd_vld && cand) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best_w   <= eff_w;
          end
        end
        S_PICK: begin
          if (found && !which) begin
            a_w       <= best_w;
            which     <= 1'b1;
            issue_idx <= '0;
            found     <= 1'b0;
          end
        end
        S_MERGE: begin
          made      <= made + 9'd1;
          which     <= 1'b0;
          issue_idx <= '0;
          found     <= 1'b0;
        end
        S_FINISH: begin
          leaf_valid <= '0;
        end
        default: ;
      endcase
    end
  end

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_tree |-> last)
    else $error("bad_tree result without last");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("result written over a waiting result");

  a_bit_live: assert property (@(posedge clk) disable iff (rst)
    state == S_BIT |-> symbols_left != '0)
    else $error("bit step with no symbols left");

  a_made_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> made[NODE_W-1] && made != NODE_BAD)
    else $error("node counter out of range during build");

endmodule
`default_nettype wire

### bench/tb_context_huffman_decoder_core.sv
`timescale 1ns / 100ps
module tb_context_huffman_decoder_core;
  import chd_pkg::*;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       bad;
  } decoded_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  op_t                    operation;
  logic [7:0]             context_req;
  logic [7:0]             symbol_index;
  logic [7:0]             data_byte;
  logic [LENGTH_BITS-1:0] frame_length;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             symbol;
  logic                   last;
  logic                   bad_tree;

  context_huffman_decoder_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .context_req(context_req),
    .symbol_index(symbol_index), .data_byte(data_byte),
    .frame_length(frame_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .symbol(symbol), .last(last), .bad_tree(bad_tree)
  );

  localparam int CTX_SPAN = 510;
  localparam int STALL_LIMIT = 60000;

  // shadow copy of the decoder state
  logic [8:0]             child_mem [0:NUM_SYMS*CTX_SPAN-1];
  logic [8:0]             root_mem [0:NUM_SYMS-1];
  logic [15:0]            weight_mem [0:NODE_COUNT-1];
  bit                     taken [0:NODE_COUNT-1];
  logic [8:0]             walk_node;
  logic [7:0]             walk_ctx;
  logic [LENGTH_BITS-1:0] left_cnt;

  decoded_t expected_q[$];
  int       errors;
  int       send_idle;
  int       recv_idle;
  int       item_cnt;
  int       stall_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_lightest(input int limit);
    int found;
    logic [15:0] best;
    found = -1;
    best = '0;
    for (int i = 0; i < limit; i++) begin
      if (!taken[i] && weight_mem[i] != 0 && (found < 0 || weight_mem[i] < best)) begin
        best = weight_mem[i];
        found = i;
      end
    end
    if (found >= 0) taken[found] = 1'b1;
    return found;
  endfunction

  function automatic void build_tree(input int c);
    int made;
    int a;
    int b;
    int slot;
    made = NUM_SYMS;
    for (int i = 0; i < NODE_COUNT; i++) taken[i] = 1'b0;
    while (made != NODE_COUNT) begin
      slot = c * CTX_SPAN + (made - NUM_SYMS) * 2;
      a = pick_lightest(made);
      if (a < 0) break;
      child_mem[slot] = 9'(a);
      b = pick_lightest(made);
      if (b < 0) break;
      child_mem[slot + 1] = 9'(b);
      weight_mem[made] = weight_mem[a] + weight_mem[b];
      made++;
    end
    root_mem[c] = 9'(made - 1);
    for (int i = 0; i < NUM_SYMS; i++) weight_mem[i] = '0;
  endfunction

  function automatic void decode_item(input op_t op, input logic [7:0] c,
                                      input logic [7:0] s, input logic [7:0] d,
                                      input logic [LENGTH_BITS-1:0] len);
    decoded_t r;
    logic [8:0] node;
    bit emitted;
    bit pending;
    pending = 1'b0;
    if (op == OP_LOAD) begin
      weight_mem[s] = {8'd0, d};
      if (s == 8'hff) build_tree(c);
    end else if (op == OP_START) begin
      left_cnt = len;
      walk_ctx = '0;
      walk_node = root_mem[0];
      if (left_cnt != 0 && !is_inner(walk_node)) begin
        left_cnt = '0;
        expected_q.push_back('{8'd0, 1'b1, 1'b1});
      end
    end else if (op == OP_BYTE && left_cnt != 0) begin
      for (int k = 0; k < 8; k++) begin
        emitted = 1'b0;
        node = walk_node;
        if (node < FIRST_INNER) begin
          left_cnt = left_cnt - 1'b1;
          emitted = 1'b1;
          if (left_cnt == 0) begin
            expected_q.push_back('{node[7:0], 1'b1, 1'b0});
            return;
          end
          r = '{node[7:0], 1'b0, 1'b0};
          walk_ctx = node[7:0];
          node = root_mem[node[7:0]];
          walk_node = node;
        end
        if (!is_inner(node)) begin
          left_cnt = '0;
          if (emitted) expected_q.push_back('{r.sym, 1'b1, 1'b1});
          else expected_q.push_back('{8'd0, 1'b1, 1'b1});
          return;
        end
        if (emitted) expected_q.push_back(r);
        walk_node = child_mem[walk_ctx * CTX_SPAN + (node - FIRST_INNER) * 2 + d[k]];
      end
    end
  endfunction

  // one item through the input handshake, predicted when accepted
  task automatic send_item(input op_t op, input logic [7:0] c, input logic [7:0] s,
                           input logic [7:0] d, input logic [LENGTH_BITS-1:0] len);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    context_req  <= c;
    symbol_index <= s;
    data_byte    <= d;
    frame_length <= len;
    do @(posedge clk); while (!in_ready);
    decode_item(op, c, s, d, len);
    item_cnt++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_count();
    return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // loads one context's tree over the given alphabet; lone gives a leaf root
  task automatic load_tree(input int c, input int alpha[$], input bit lone);
    logic [7:0] cnt;
    logic [7:0] cnt_top;
    bit has_top;
    has_top = 1'b0;
    cnt_top = '0;
    foreach (alpha[i]) begin
      cnt = lone ? ((i == 0) ? 8'd1 : 8'd0) : rand_count();
      if (alpha[i] == 255) begin
        has_top = 1'b1;
        cnt_top = cnt;
      end else if (cnt != 0 || $urandom_range(0, 1)) begin
        send_item(OP_LOAD, 8'(c), 8'(alpha[i]), cnt, LENGTH_BITS'($urandom));
      end
    end
    send_item(OP_LOAD, 8'(c), 8'hff, has_top ? cnt_top : 8'd0, LENGTH_BITS'($urandom));
  endtask

  task automatic run_frame(input logic [LENGTH_BITS-1:0] len, input int max_bytes);
    int n;
    n = 0;
    send_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom), len);
    while (left_cnt != 0 && n < max_bytes) begin
      if ($urandom_range(0, 15) == 0)
        send_item(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom), LENGTH_BITS'($urandom));
      send_item(OP_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), LENGTH_BITS'($urandom));
      n++;
    end
  endtask

  task automatic test_directed();
    int alpha[$];
    // context 0 with a single symbol: start ends at once as a bad tree
    alpha = '{5};
    load_tree(0, alpha, 1'b1);
    run_frame(20'd3, 4);
    run_frame(20'd0, 0);
    send_item(OP_BYTE, 8'd0, 8'd0, 8'hff, 20'd0);
    send_item(OP_NONE, 8'hff, 8'hff, 8'hff, 20'hfffff);
    alpha = '{0, 255, 7};
    send_item(OP_LOAD, 8'd0, 8'd0, 8'd255, 20'd0);
    send_item(OP_LOAD, 8'd0, 8'd7, 8'd1, 20'd0);
    send_item(OP_LOAD, 8'd0, 8'hff, 8'd255, 20'd0);
    load_tree(255, alpha, 1'b0);
    load_tree(7, alpha, 1'b1);
    run_frame(20'd1, 2);
    run_frame(20'hfffff, 3);
    run_frame(20'd6, 8);
    wait_drained();
  endtask

  task automatic test_random(input int quota, input int s_idle, input int r_idle);
    int alpha[$];
    int k;
    int stop_at;
    send_idle = s_idle;
    recv_idle = r_idle;
    stop_at = item_cnt + quota;
    while (item_cnt < stop_at) begin
      alpha = '{0};
      k = $urandom_range(1, 5);
      while (alpha.size() <= k) begin
        int v;
        bit dup;
        v = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 254);
        dup = 1'b0;
        foreach (alpha[i]) if (alpha[i] == v) dup = 1'b1;
        if (!dup) alpha.push_back(v);
      end
      foreach (alpha[i]) load_tree(alpha[i], alpha, $urandom_range(0, 9) == 0);
      for (int f = 0; f < 4; f++) begin
        case ($urandom_range(0, 9))
          0: run_frame(20'd0, 0);
          1: run_frame(LENGTH_BITS'($urandom_range(1, 20'hfffff)), 3);
          default: run_frame(LENGTH_BITS'($urandom_range(1, 30)), 12);
        endcase
      end
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected item: sym %h last %b bad %b", $time, symbol, last, bad_tree);
        errors++;
      end else begin
        decoded_t e;
        e = expected_q.pop_front();
        if (e.sym !== symbol) begin
          $display("%0t symbol: expected %h actual %h", $time, e.sym, symbol);
          errors++;
        end
        if (e.last !== last) begin
          $display("%0t last: expected %b actual %b", $time, e.last, last);
          errors++;
        end
        if (e.bad !== bad_tree) begin
          $display("%0t bad_tree: expected %b actual %b", $time, e.bad, bad_tree);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_NONE;
    context_req = '0;
    symbol_index = '0;
    data_byte = '0;
    frame_length = '0;
    out_ready = 1'b0;
    errors = 0;
    item_cnt = 0;
    stall_cnt = 0;
    send_idle = 0;
    recv_idle = 0;
    walk_node = '0;
    walk_ctx = '0;
    left_cnt = '0;
    for (int i = 0; i < NODE_COUNT; i++) weight_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(65, 31, 84);
    test_random(65, 84, 31);
    test_random(65, 0, 0);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    errors += expected_q.size();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### context_huffman_decoder_core.f
hdl/chd_pkg.sv
hdl/chd_ram.sv
hdl/context_huffman_decoder_core.sv
bench/tb_context_huffman_decoder_core.sv
